// ===== rtl/dfwcg_pkg.sv =====
// Shared types and constants for the display fill-window command generator.
// Holds command codes, register indexes and the per-axis clip result type.
// No dependencies.
package dfwcg_pkg;

    // Display controller command codes.
    localparam logic [7:0] CMD_COLUMN = 8'h2A;
    localparam logic [7:0] CMD_ROW    = 8'h2B;
    localparam logic [7:0] CMD_WRITE  = 8'h2C;

    // Window cache value after reset or a write to any configuration register.
    localparam logic [15:0] CACHE_EMPTY = 16'hFFFF;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_ROTATION      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COL_OFF_FIRST = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COL_OFF_LAST  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_OFF_FIRST = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_OFF_LAST  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_MODE     = 4'd7;

    // Result of clipping one axis against the rotated panel edge.
    typedef struct packed {
        logic [9:0] start;
        logic [9:0] len;
        logic       empty;
    } axis_clip_t;

endpackage

// ===== rtl/dfwcg_clip.sv =====
// Clips one axis (position and size) of a fill rectangle to the panel extent.
// Purely combinational; depends on dfwcg_pkg for the result type.
module dfwcg_clip (
    input  logic signed [15:0]  pos,
    input  logic signed [15:0]  size,
    input  logic [9:0]          limit,
    output dfwcg_pkg::axis_clip_t clip
);
    import dfwcg_pkg::*;

    logic signed [17:0] pos_e;
    logic signed [17:0] size_e;
    logic signed [17:0] lim_e;
    logic signed [17:0] start_e;
    logic signed [17:0] len_a;
    logic signed [17:0] sum_e;
    logic signed [17:0] len_e;

    // A negative position shortens the size and moves the start to zero,
    // then the size is cut back at the panel edge.
    always_comb
    begin
        pos_e   = {{2{pos[15]}}, pos};
        size_e  = {{2{size[15]}}, size};
        lim_e   = {8'd0, limit};
        start_e = pos_e[17] ? 18'sd0 : pos_e;
        len_a   = pos_e[17] ? (size_e + pos_e) : size_e;
        sum_e   = start_e + len_a;
        len_e   = (sum_e > lim_e) ? (lim_e - start_e) : len_a;

        clip.start = start_e[9:0];
        clip.len   = len_e[9:0];
        clip.empty = len_e[17] || (len_e == 18'sd0);
    end

endmodule

// ===== rtl/display_fill_window_command_gen.sv =====
// Top level of the display fill-window command generator.
// Depends on dfwcg_pkg and instantiates dfwcg_clip for each axis.
//
// Each accepted fill request is clipped to the panel under the current
// rotation and turned into at most three transfers on the result channel:
// a column-address command, a row-address command and a memory-write command
// that carries the pixel count and color and has last set. A request that
// clips to an empty area gives no transfer. Address commands that repeat the
// cached window are dropped; with the pair mode register set, both go out
// whenever either changed. Any valid register write clears the window cache.
// The block runs an input register, a clip register, a command register and
// an output register, in that order. A request sends its commands through
// the output port one result per cycle while out_ready keeps the port free,
// and the number of commands per request sets the sustained rate. A new
// request is taken in every cycle that the pipeline is not backed up by the
// output port. Register writes are taken at any time (cfg_ready is always high)
// and must only be issued while the block is idle.
module display_fill_window_command_gen (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dfwcg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dfwcg_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Fill request channel.
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [15:0]                 rect_x,
    input  logic signed [15:0]                 rect_y,
    input  logic signed [15:0]                 rect_w,
    input  logic signed [15:0]                 rect_h,
    input  logic [15:0]                        fill_color,
    // Command result channel.
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         command_code,
    output logic [15:0]                        arg_start,
    output logic [15:0]                        arg_end,
    output logic [15:0]                        color_out,
    output logic [20:0]                        pixel_count,
    output logic                               last
);
    import dfwcg_pkg::*;

    // Configuration registers.
    logic [1:0] rotation_reg;
    logic [9:0] panel_width_reg;
    logic [9:0] panel_height_reg;
    logic [8:0] col_off_first_reg;
    logic [8:0] col_off_last_reg;
    logic [8:0] row_off_first_reg;
    logic [8:0] row_off_last_reg;
    logic       pair_mode_reg;
    logic       cfg_fire;
    logic       cfg_hit;

    // Window cache.
    logic [15:0] cache_x_reg;
    logic [15:0] cache_w_reg;
    logic [15:0] cache_y_reg;
    logic [15:0] cache_h_reg;

    // Input register.
    logic               in_valid_reg;
    logic signed [15:0] in_x_reg;
    logic signed [15:0] in_y_reg;
    logic signed [15:0] in_w_reg;
    logic signed [15:0] in_h_reg;
    logic [15:0]        in_color_reg;

    // Clip register.
    logic        cl_valid_reg;
    logic [9:0]  cl_x_reg;
    logic [9:0]  cl_w_reg;
    logic [9:0]  cl_y_reg;
    logic [9:0]  cl_h_reg;
    logic [15:0] cl_color_reg;

    // Command register.
    logic        job_valid_reg;
    logic        job_col_reg;
    logic        job_row_reg;
    logic [15:0] job_col_start_reg;
    logic [15:0] job_col_end_reg;
    logic [15:0] job_row_start_reg;
    logic [15:0] job_row_end_reg;
    logic [20:0] job_count_reg;
    logic [15:0] job_color_reg;

    // Output register.
    logic        out_valid_reg;
    logic [7:0]  out_code_reg;
    logic [15:0] out_start_reg;
    logic [15:0] out_end_reg;
    logic [15:0] out_color_reg;
    logic [20:0] out_count_reg;
    logic        out_last_reg;

    // Pipeline control.
    logic out_free;
    logic emit;
    logic emit_last;
    logic job_free;
    logic job_load;
    logic cl_free;
    logic cl_load;
    logic in_free;
    logic in_fire;

    // Clip stage signals.
    logic       land;
    logic [9:0] view_w;
    logic [9:0] view_h;
    axis_clip_t clip_x;
    axis_clip_t clip_y;

    // Decision stage signals.
    logic [8:0]  x_off;
    logic [8:0]  y_off;
    logic        x_changed;
    logic        y_changed;
    logic        both;
    logic        need_col;
    logic        need_row;
    logic [19:0] area;
    logic [15:0] col_start_next;
    logic [15:0] col_end_next;
    logic [15:0] row_start_next;
    logic [15:0] row_end_next;

    // Emitter selection.
    logic [7:0]  emit_code;
    logic [15:0] emit_start;
    logic [15:0] emit_end;
    logic [15:0] emit_color;
    logic [20:0] emit_count;

    // Handshake chain from the output port back to the input port.
    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = job_valid_reg && out_free;
    assign emit_last = emit && !job_col_reg && !job_row_reg;
    assign job_free  = !job_valid_reg || emit_last;
    assign job_load  = cl_valid_reg && job_free;
    assign cl_free   = !cl_valid_reg || job_free;
    assign cl_load   = in_valid_reg && cl_free;
    assign in_free   = !in_valid_reg || cl_free;
    assign in_fire   = in_valid && in_free;

    assign in_ready  = in_free;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;

    // Configuration register decode.
    always_comb
    begin
        unique case (cfg_index) inside
            REG_ROTATION,
            REG_PANEL_WIDTH,
            REG_PANEL_HEIGHT,
            REG_COL_OFF_FIRST,
            REG_COL_OFF_LAST,
            REG_ROW_OFF_FIRST,
            REG_ROW_OFF_LAST,
            REG_PAIR_MODE: cfg_hit = cfg_fire;
            default:       cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg      <= 2'd0;
            panel_width_reg   <= 10'd240;
            panel_height_reg  <= 10'd320;
            col_off_first_reg <= 9'd0;
            col_off_last_reg  <= 9'd0;
            row_off_first_reg <= 9'd0;
            row_off_last_reg  <= 9'd0;
            pair_mode_reg     <= 1'b0;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_ROTATION:      rotation_reg      <= cfg_data[1:0];
                REG_PANEL_WIDTH:   panel_width_reg   <= cfg_data[9:0];
                REG_PANEL_HEIGHT:  panel_height_reg  <= cfg_data[9:0];
                REG_COL_OFF_FIRST: col_off_first_reg <= cfg_data[8:0];
                REG_COL_OFF_LAST:  col_off_last_reg  <= cfg_data[8:0];
                REG_ROW_OFF_FIRST: row_off_first_reg <= cfg_data[8:0];
                REG_ROW_OFF_LAST:  row_off_last_reg  <= cfg_data[8:0];
                REG_PAIR_MODE:     pair_mode_reg     <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_free)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_x_reg     <= rect_x;
            in_y_reg     <= rect_y;
            in_w_reg     <= rect_w;
            in_h_reg     <= rect_h;
            in_color_reg <= fill_color;
        end
    end

    // Panel extent as seen under the current rotation.
    assign land   = rotation_reg[0];
    assign view_w = land ? panel_height_reg : panel_width_reg;
    assign view_h = land ? panel_width_reg : panel_height_reg;

    dfwcg_clip u_clip_x (
        .pos   (in_x_reg),
        .size  (in_w_reg),
        .limit (view_w),
        .clip  (clip_x)
    );

    dfwcg_clip u_clip_y (
        .pos   (in_y_reg),
        .size  (in_h_reg),
        .limit (view_h),
        .clip  (clip_y)
    );

    // Clip register; an empty area is dropped here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cl_valid_reg <= 1'b0;
        end
        else if (cl_free)
        begin
            cl_valid_reg <= in_valid_reg && !clip_x.empty && !clip_y.empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cl_load)
        begin
            cl_x_reg     <= clip_x.start;
            cl_w_reg     <= clip_x.len;
            cl_y_reg     <= clip_y.start;
            cl_h_reg     <= clip_y.len;
            cl_color_reg <= in_color_reg;
        end
    end

    // RAM offsets per rotation.
    always_comb
    begin
        unique case (rotation_reg)
            2'd1:
            begin
                x_off = row_off_first_reg;
                y_off = col_off_last_reg;
            end
            2'd2:
            begin
                x_off = col_off_last_reg;
                y_off = row_off_last_reg;
            end
            2'd3:
            begin
                x_off = row_off_last_reg;
                y_off = col_off_first_reg;
            end
            default:
            begin
                x_off = col_off_first_reg;
                y_off = row_off_first_reg;
            end
        endcase
    end

    // Cache compare, address sums and pixel count.
    always_comb
    begin
        x_changed = ({6'd0, cl_x_reg} != cache_x_reg) || ({6'd0, cl_w_reg} != cache_w_reg);
        y_changed = ({6'd0, cl_y_reg} != cache_y_reg) || ({6'd0, cl_h_reg} != cache_h_reg);
        both      = pair_mode_reg && (x_changed || y_changed);
        need_col  = x_changed || both;
        need_row  = y_changed || both;

        col_start_next = {6'd0, cl_x_reg} + {7'd0, x_off};
        col_end_next   = {6'd0, cl_x_reg} + {6'd0, cl_w_reg} - 16'd1 + {7'd0, x_off};
        row_start_next = {6'd0, cl_y_reg} + {7'd0, y_off};
        row_end_next   = {6'd0, cl_y_reg} + {6'd0, cl_h_reg} - 16'd1 + {7'd0, y_off};
        area           = {10'd0, cl_w_reg} * {10'd0, cl_h_reg};
    end

    // Window cache: cleared by a register write, updated as commands are queued.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_x_reg <= CACHE_EMPTY;
            cache_w_reg <= CACHE_EMPTY;
            cache_y_reg <= CACHE_EMPTY;
            cache_h_reg <= CACHE_EMPTY;
        end
        else if (cfg_hit)
        begin
            cache_x_reg <= CACHE_EMPTY;
            cache_w_reg <= CACHE_EMPTY;
            cache_y_reg <= CACHE_EMPTY;
            cache_h_reg <= CACHE_EMPTY;
        end
        else if (job_load)
        begin
            if (need_col)
            begin
                cache_x_reg <= {6'd0, cl_x_reg};
                cache_w_reg <= {6'd0, cl_w_reg};
            end
            if (need_row)
            begin
                cache_y_reg <= {6'd0, cl_y_reg};
                cache_h_reg <= {6'd0, cl_h_reg};
            end
        end
    end

    // Command register with pending flags for the address commands.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            job_col_reg   <= 1'b0;
            job_row_reg   <= 1'b0;
        end
        else if (job_free)
        begin
            job_valid_reg <= cl_valid_reg;
            job_col_reg   <= cl_valid_reg && need_col;
            job_row_reg   <= cl_valid_reg && need_row;
        end
        else if (emit)
        begin
            if (job_col_reg)
            begin
                job_col_reg <= 1'b0;
            end
            else
            begin
                job_row_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_col_start_reg <= col_start_next;
            job_col_end_reg   <= col_end_next;
            job_row_start_reg <= row_start_next;
            job_row_end_reg   <= row_end_next;
            job_count_reg     <= {1'b0, area};
            job_color_reg     <= cl_color_reg;
        end
    end

    // Pick the next command to send: column, then row, then memory write.
    always_comb
    begin
        if (job_col_reg)
        begin
            emit_code  = CMD_COLUMN;
            emit_start = job_col_start_reg;
            emit_end   = job_col_end_reg;
            emit_color = 16'd0;
            emit_count = 21'd0;
        end
        else if (job_row_reg)
        begin
            emit_code  = CMD_ROW;
            emit_start = job_row_start_reg;
            emit_end   = job_row_end_reg;
            emit_color = 16'd0;
            emit_count = 21'd0;
        end
        else
        begin
            emit_code  = CMD_WRITE;
            emit_start = 16'd0;
            emit_end   = 16'd0;
            emit_color = job_color_reg;
            emit_count = job_count_reg;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_code_reg  <= emit_code;
            out_start_reg <= emit_start;
            out_end_reg   <= emit_end;
            out_color_reg <= emit_color;
            out_count_reg <= emit_count;
            out_last_reg  <= emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign command_code = out_code_reg;
    assign arg_start    = out_start_reg;
    assign arg_end      = out_end_reg;
    assign color_out    = out_color_reg;
    assign pixel_count  = out_count_reg;
    assign last         = out_last_reg;

endmodule
